### hdl/iet_pkg.sv
// Shared types and constants for the ini/env line tokenizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package iet_pkg;

	localparam int MAX_LINE_LEN = 4096;
	localparam int OFS_W        = $clog2(MAX_LINE_LEN + 1);
	localparam int SLOTS        = 8;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);

	localparam logic [15:0] CH_SEMI   = 16'h003B;
	localparam logic [15:0] CH_HASH   = 16'h0023;
	localparam logic [15:0] CH_LBRK   = 16'h005B;
	localparam logic [15:0] CH_RBRK   = 16'h005D;
	localparam logic [15:0] CH_EQ     = 16'h003D;
	localparam logic [15:0] CH_COLON  = 16'h003A;
	localparam logic [15:0] CH_DOT    = 16'h002E;
	localparam logic [15:0] CH_SPACE  = 16'h0020;
	localparam logic [15:0] CH_TAB    = 16'h0009;
	localparam logic [15:0] CH_DQUOTE = 16'h0022;
	localparam logic [15:0] CH_SQUOTE = 16'h0027;
	localparam logic [15:0] CH_ZERO   = 16'h0030;
	localparam logic [15:0] CH_NINE   = 16'h0039;

	typedef enum logic [1:0] {
		REG_INI_MODE = 2'd0,
		REG_TOKEN_CAP = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_PLAIN   = 3'd0,
		K_COMMENT = 3'd1,
		K_SECTION = 3'd2,
		K_KEY     = 3'd3,
		K_OPER    = 3'd4,
		K_STRING  = 3'd5,
		K_NUMBER  = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		PH_LEAD        = 4'd0,
		PH_COMMENT     = 4'd1,
		PH_SECTION     = 4'd2,
		PH_KEY         = 4'd3,
		PH_VLEAD       = 4'd4,
		PH_STRING      = 4'd5,
		PH_NUMBER      = 4'd6,
		PH_PLAINREST   = 4'd7,
		PH_TRAILBLANK  = 4'd8,
		PH_TRAILCOMMENT= 4'd9,
		PH_TRAILPLAIN  = 4'd10
	} phase_t;

	typedef struct packed {
		logic [15:0] char_code;
		logic        end_of_line;
	} chr_t;

	typedef struct packed {
		logic [OFS_W-1:0] span_start;
		logic [OFS_W-1:0] span_end;
		logic [2:0]       span_kind;
		logic             line_truncated;
		logic             last_of_run;
	} span_out_t;

	typedef struct packed {
		logic [OFS_W-1:0] from;
		logic [OFS_W-1:0] to;
		kind_t            kind;
	} span_t;

	// All spans caused by one character, packed from slot 0 up.
	typedef struct packed {
		span_t [SLOTS-1:0]  span;
		logic  [SLOT_W:0]   cnt;
		logic               trunc;
	} bundle_t;

	function automatic span_t mk_span(logic [OFS_W-1:0] f, logic [OFS_W-1:0] t, kind_t k);
		span_t s;
		s.from = f;
		s.to   = t;
		s.kind = k;
		return s;
	endfunction

endpackage

### hdl/iet_front.sv
// Front part: per-character parser, span generation and capacity filter.
// Depends on iet_pkg.
`timescale 1ns / 1ps
module iet_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  iet_pkg::chr_t    chr,
	input  logic             ini_mode,
	input  logic [6:0]       token_capacity,
	output logic             bundle_valid,
	output iet_pkg::bundle_t bundle
);

	iet_pkg::phase_t                 phase_q, ph;
	logic [iet_pkg::OFS_W-1:0]       line_offset_q, lo_n;
	logic [iet_pkg::OFS_W-1:0]       pending_start_q, ps;
	logic [iet_pkg::OFS_W-1:0]       last_nonblank_end_q, lne;
	logic [iet_pkg::OFS_W-1:0]       number_end_mark_q, nem;
	logic                            quote_is_single_q, qs;
	logic                            dot_seen_q, dot;
	logic [6:0]                      spans_emitted_q;
	logic                            overlong_q, ovl;
	iet_pkg::span_t [iet_pkg::SLOTS-1:0] raw;
	logic [iet_pkg::SLOT_W:0]        n_raw;
	iet_pkg::span_t [iet_pkg::SLOTS-1:0] kept;
	logic [iet_pkg::SLOT_W:0]        n_kept;
	logic [7:0]                      emitted;
	logic [15:0]                     c;
	logic [iet_pkg::OFS_W-1:0]       p, p1;
	logic                            is_blank, is_cmark, is_num, is_sep, again;

	assign c        = chr.char_code;
	assign p        = line_offset_q;
	assign p1       = line_offset_q + iet_pkg::OFS_W'(1);
	assign is_blank = (c == iet_pkg::CH_SPACE) || (c == iet_pkg::CH_TAB);
	assign is_cmark = (c == iet_pkg::CH_SEMI) || (c == iet_pkg::CH_HASH);
	assign is_num   = (c >= iet_pkg::CH_ZERO) && (c <= iet_pkg::CH_NINE);
	assign is_sep   = (c == iet_pkg::CH_EQ) || (ini_mode && (c == iet_pkg::CH_COLON));

	// Raw spans in emit order; at most three passes of the phase handler.
	always_comb begin
		ph    = phase_q;
		ps    = pending_start_q;
		lne   = last_nonblank_end_q;
		nem   = number_end_mark_q;
		qs    = quote_is_single_q;
		dot   = dot_seen_q;
		ovl   = overlong_q;
		lo_n  = line_offset_q;
		raw   = '0;
		n_raw = '0;
		again = 1'b0;
		if (line_offset_q >= iet_pkg::OFS_W'(iet_pkg::MAX_LINE_LEN)) begin
			ovl = 1'b1;
		end else begin
			again = 1'b1;
			lo_n  = p1;
		end
		for (int it = 0; it < 3; it++) begin
			if (again) begin
				again = 1'b0;
				case (ph)
					iet_pkg::PH_LEAD: begin
						if (!is_blank) begin
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span('0, p, iet_pkg::K_PLAIN);
							n_raw = n_raw + 1'b1;
							ps  = p;
							lne = p;
							if (is_cmark) ph = iet_pkg::PH_COMMENT;
							else if (ini_mode && c == iet_pkg::CH_LBRK) ph = iet_pkg::PH_SECTION;
							else begin
								ph    = iet_pkg::PH_KEY;
								again = 1'b1;
							end
						end
					end
					iet_pkg::PH_SECTION: begin
						if (c == iet_pkg::CH_RBRK && p > ps) begin
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, p1, iet_pkg::K_SECTION);
							n_raw = n_raw + 1'b1;
							ps = p1;
							ph = iet_pkg::PH_TRAILBLANK;
						end
					end
					iet_pkg::PH_KEY: begin
						if (is_sep) begin
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, lne, iet_pkg::K_KEY);
							n_raw = n_raw + 1'b1;
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(lne, p, iet_pkg::K_PLAIN);
							n_raw = n_raw + 1'b1;
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(p, p1, iet_pkg::K_OPER);
							n_raw = n_raw + 1'b1;
							ps = p1;
							ph = iet_pkg::PH_VLEAD;
						end else if (!is_blank) begin
							lne = p1;
						end
					end
					iet_pkg::PH_VLEAD: begin
						if (!is_blank) begin
							if (c == iet_pkg::CH_DQUOTE || c == iet_pkg::CH_SQUOTE) begin
								raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, p, iet_pkg::K_PLAIN);
								n_raw = n_raw + 1'b1;
								ps = p;
								qs = (c == iet_pkg::CH_SQUOTE);
								ph = iet_pkg::PH_STRING;
							end else begin
								nem   = p;
								dot   = 1'b0;
								ph    = iet_pkg::PH_NUMBER;
								again = 1'b1;
							end
						end
					end
					iet_pkg::PH_STRING: begin
						if (c == (qs ? iet_pkg::CH_SQUOTE : iet_pkg::CH_DQUOTE)) begin
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, p1, iet_pkg::K_STRING);
							n_raw = n_raw + 1'b1;
							ps = p1;
							ph = iet_pkg::PH_TRAILBLANK;
						end
					end
					iet_pkg::PH_NUMBER: begin
						if (is_num) begin
							dot = dot;
						end else if (c == iet_pkg::CH_DOT && !dot) begin
							dot = 1'b1;
						end else begin
							if (p > nem && (is_blank || is_cmark)) begin
								raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, nem, iet_pkg::K_PLAIN);
								n_raw = n_raw + 1'b1;
								raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(nem, p, iet_pkg::K_NUMBER);
								n_raw = n_raw + 1'b1;
								ps    = p;
								ph    = iet_pkg::PH_TRAILBLANK;
								again = 1'b1;
							end else begin
								ph = iet_pkg::PH_PLAINREST;
							end
							dot = 1'b0;
						end
					end
					iet_pkg::PH_TRAILBLANK: begin
						if (!is_blank) begin
							raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, p, iet_pkg::K_PLAIN);
							n_raw = n_raw + 1'b1;
							ps = p;
							ph = is_cmark ? iet_pkg::PH_TRAILCOMMENT : iet_pkg::PH_TRAILPLAIN;
						end
					end
					default: begin
						ph = ph;
					end
				endcase
			end
		end
		// Close whatever is open at end of line.
		if (chr.end_of_line) begin
			case (ph)
				iet_pkg::PH_LEAD: begin
					raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span('0, lo_n, iet_pkg::K_PLAIN);
					n_raw = n_raw + 1'b1;
				end
				iet_pkg::PH_COMMENT, iet_pkg::PH_TRAILCOMMENT: begin
					raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, lo_n, iet_pkg::K_COMMENT);
					n_raw = n_raw + 1'b1;
				end
				iet_pkg::PH_STRING: begin
					raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, lo_n, iet_pkg::K_STRING);
					n_raw = n_raw + 1'b1;
				end
				iet_pkg::PH_NUMBER: begin
					raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, nem, iet_pkg::K_PLAIN);
					n_raw = n_raw + 1'b1;
					raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(nem, lo_n, iet_pkg::K_NUMBER);
					n_raw = n_raw + 1'b1;
				end
				default: begin
					raw[n_raw[iet_pkg::SLOT_W-1:0]] = iet_pkg::mk_span(ps, lo_n, iet_pkg::K_PLAIN);
					n_raw = n_raw + 1'b1;
				end
			endcase
		end
	end

	// Drop empty spans and those past the per-line budget, then pack.
	always_comb begin
		kept    = '0;
		n_kept  = '0;
		emitted = {1'b0, spans_emitted_q};
		for (int i = 0; i < iet_pkg::SLOTS; i++) begin
			if ((iet_pkg::SLOT_W+1)'(i) < n_raw && raw[i].from < raw[i].to &&
			    emitted < {1'b0, token_capacity}) begin
				kept[n_kept[iet_pkg::SLOT_W-1:0]] = raw[i];
				n_kept  = n_kept + 1'b1;
				emitted = emitted + 8'd1;
			end
		end
	end

	assign bundle_valid = take && (n_kept != '0);
	assign bundle.span  = kept;
	assign bundle.cnt   = n_kept;
	assign bundle.trunc = ovl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q             <= iet_pkg::PH_LEAD;
			line_offset_q       <= '0;
			pending_start_q     <= '0;
			last_nonblank_end_q <= '0;
			number_end_mark_q   <= '0;
			quote_is_single_q   <= 1'b0;
			dot_seen_q          <= 1'b0;
			spans_emitted_q     <= '0;
			overlong_q          <= 1'b0;
		end else if (take) begin
			if (chr.end_of_line) begin
				phase_q             <= iet_pkg::PH_LEAD;
				line_offset_q       <= '0;
				pending_start_q     <= '0;
				last_nonblank_end_q <= '0;
				number_end_mark_q   <= '0;
				quote_is_single_q   <= 1'b0;
				dot_seen_q          <= 1'b0;
				spans_emitted_q     <= '0;
				overlong_q          <= 1'b0;
			end else begin
				phase_q             <= ph;
				line_offset_q       <= lo_n;
				pending_start_q     <= ps;
				last_nonblank_end_q <= lne;
				number_end_mark_q   <= nem;
				quote_is_single_q   <= qs;
				dot_seen_q          <= dot;
				spans_emitted_q     <= emitted[6:0];
				overlong_q          <= ovl;
			end
		end
	end

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_offset_q <= iet_pkg::OFS_W'(iet_pkg::MAX_LINE_LEN))
		else $error("line offset past maximum");
	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		take && !chr.end_of_line && spans_emitted_q <= token_capacity |=>
		spans_emitted_q <= $past(token_capacity))
		else $error("span budget exceeded");
	a_overlong_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overlong_q && !(take && chr.end_of_line) |=> overlong_q)
		else $error("overlong flag lost mid-line");

endmodule

### hdl/iet_span_queue.sv
// Back part: bundle queue and span serializer, one span per pop.
// Depends on iet_pkg.
`timescale 1ns / 1ps
module iet_span_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  iet_pkg::bundle_t    wr_data,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output iet_pkg::span_out_t  span
);

	iet_pkg::bundle_t           mem_q [iet_pkg::QDEPTH];
	logic [iet_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [iet_pkg::QPTR_W:0]   count_q;
	logic [iet_pkg::SLOT_W-1:0] sel_q;
	iet_pkg::bundle_t           head;
	logic                       is_last, rd_done;

	assign head    = mem_q[rd_ptr_q];
	assign full    = (count_q == (iet_pkg::QPTR_W+1)'(iet_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign is_last = ({1'b0, sel_q} == head.cnt - 1'b1);
	assign rd_done = pop && !empty && is_last;

	assign span.span_start     = head.span[sel_q].from;
	assign span.span_end       = head.span[sel_q].to;
	assign span.span_kind      = head.span[sel_q].kind;
	assign span.line_truncated = head.trunc;
	assign span.last_of_run    = is_last;

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sel_q    <= '0;
		end else begin
			if (wr && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_done) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (iet_pkg::QPTR_W+1)'(wr && !full) -
			           (iet_pkg::QPTR_W+1)'(rd_done);
			if (pop && !empty) sel_q <= is_last ? '0 : sel_q + 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (iet_pkg::QPTR_W+1)'(iet_pkg::QDEPTH))
		else $error("queue count overflow");
	a_no_empty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> wr_data.cnt != '0)
		else $error("empty bundle queued");
	a_sel_reset: assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |=> sel_q == '0)
		else $error("slot select not rewound");

endmodule

### hdl/ini_env_line_tokenizer_core.sv
// Top level of the ini/env line tokenizer: config registers, front, back.
// Depends on iet_pkg, iet_front, iet_span_queue.
`timescale 1ns / 1ps
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------
//  input    | push / full       | chr  : char_code, end_of_line
//  result   | pop / empty       | span : span_start, span_end, span_kind,
//           |                   |        line_truncated, last_of_run
//  config   | cfg_we            | cfg_index, cfg_data (0 ini_mode, 1 cap)
//
//  One character per cycle is accepted while full is low; the parser
//  state update is combinational work in the front, registered on take.
//  Each character yields zero to three spans; the back drains one span
//  per pop, so the result side bounds sustained rate when lines are dense.
//  The four-entry bundle queue lets either side stall independently.
//  Reset (arst_n low) returns to line start and ini_mode=1, capacity=16.
module ini_env_line_tokenizer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  iet_pkg::chr_t      chr,
	output logic               empty,
	input  logic               pop,
	output iet_pkg::span_out_t span,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	logic             ini_mode_q;
	logic [6:0]       token_capacity_q;
	logic             take;
	logic             bundle_valid;
	iet_pkg::bundle_t bundle;

	// Config registers; out-of-range indexes fall to the default arm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ini_mode_q       <= 1'b1;
			token_capacity_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				iet_pkg::REG_INI_MODE:  ini_mode_q       <= cfg_data[0];
				iet_pkg::REG_TOKEN_CAP: token_capacity_q <= cfg_data;
				default: ini_mode_q <= ini_mode_q;
			endcase
		end
	end

	// A transaction is taken whenever the queue has room.
	assign take = push && !full;

	iet_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.chr            (chr),
		.ini_mode       (ini_mode_q),
		.token_capacity (token_capacity_q),
		.bundle_valid   (bundle_valid),
		.bundle         (bundle)
	);

	iet_span_queue u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (bundle_valid),
		.wr_data (bundle),
		.full    (full),
		.empty   (empty),
		.pop     (pop),
		.span    (span)
	);

endmodule
